[sv/forest_completion_tree_counter_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the forest completion tree counter
// Shared shorthand for the concurrent checks of the block, clocked on clk_i
// and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef FOREST_COMPLETION_TREE_COUNTER_DEFINES_SVH
`define FOREST_COMPLETION_TREE_COUNTER_DEFINES_SVH

// Same-cycle implication.
`define FCTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fctc_pkg.sv]
// ---------------------------------------------------------------------------
// fctc_pkg
// Types and constants shared by the forest completion tree counter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fctc_pkg;

  // Default store depth.
  localparam int unsigned FCTC_MAX_VERTICES = 4096;

  // Widths fixed by the interface.
  localparam int unsigned VTX_W = 13;
  localparam int unsigned MOD_W = 30;

  // Modulus of the count.
  localparam logic [MOD_W-1:0] FCTC_MODULUS = 30'd987654323;

  // Write enables of the three store fields.
  typedef struct packed {
    logic parent;
    logic size;
    logic rank;
  } fctc_wen_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_UNION_P,
    ST_UNION_S,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_MUL,
    ST_SCAN_END,
    ST_EXP_CHK,
    ST_EXP_MUL,
    ST_EXP_SQR,
    ST_FINAL
  } fctc_state_e;

endpackage

[sv/fctc_mulmod.sv]
// ---------------------------------------------------------------------------
// fctc_mulmod
// Bit-serial modular multiplier: one bit of the first operand per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fctc_mulmod import fctc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MOD_W-1:0] a_i,
  input  logic [MOD_W-1:0] b_i,
  output logic             done_o,
  output logic [MOD_W-1:0] res_o
);

  localparam int unsigned CNT_W = $clog2(MOD_W);
  localparam int unsigned T_W   = MOD_W + 2;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MOD_W-1:0] acc_q, acc_d;
  logic [MOD_W-1:0] a_q, a_d;
  logic [MOD_W-1:0] b_q, b_d;
  logic [T_W-1:0]   sum;
  logic [T_W-1:0]   sub1;
  logic [T_W-1:0]   sub2;

  // Double the accumulator, add the operand and fold back below the modulus.
  always_comb begin
    sum  = {1'b0, acc_q, 1'b0} + (a_q[MOD_W-1] ? T_W'(b_q) : '0);
    sub1 = sum - T_W'(FCTC_MODULUS);
    sub2 = sum - {1'b0, FCTC_MODULUS, 1'b0};
  end

  // Step control.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MOD_W - 1);
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      if (sum >= {1'b0, FCTC_MODULUS, 1'b0}) begin
        acc_d = sub2[MOD_W-1:0];
      end else if (sum >= T_W'(FCTC_MODULUS)) begin
        acc_d = sub1[MOD_W-1:0];
      end else begin
        acc_d = sum[MOD_W-1:0];
      end
      a_d = {a_q[MOD_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

[sv/fctc_store.sv]
// ---------------------------------------------------------------------------
// fctc_store
// Union-find store: parent, component size and rank, one read and one write
// address per cycle, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fctc_store import fctc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = FCTC_MAX_VERTICES,
  parameter int unsigned AW = $clog2(MAX_VERTICES),
  parameter int unsigned SW = $clog2(MAX_VERTICES + 1),
  parameter int unsigned RW = $clog2(AW + 1)
) (
  input  logic          clk_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [AW-1:0] rd_parent_o,
  output logic [SW-1:0] rd_size_o,
  output logic [RW-1:0] rd_rank_o,
  input  logic [AW-1:0] wr_addr_i,
  input  fctc_wen_t     wr_en_i,
  input  logic [AW-1:0] wr_parent_i,
  input  logic [SW-1:0] wr_size_i,
  input  logic [RW-1:0] wr_rank_i
);

  logic [AW-1:0] parent_mem [MAX_VERTICES];
  logic [SW-1:0] size_mem   [MAX_VERTICES];
  logic [RW-1:0] rank_mem   [MAX_VERTICES];

  // Writes.
  always_ff @(posedge clk_i) begin
    if (wr_en_i.parent) begin
      parent_mem[wr_addr_i] <= wr_parent_i;
    end
    if (wr_en_i.size) begin
      size_mem[wr_addr_i] <= wr_size_i;
    end
    if (wr_en_i.rank) begin
      rank_mem[wr_addr_i] <= wr_rank_i;
    end
  end

  // Registered reads.
  always_ff @(posedge clk_i) begin
    rd_parent_o <= parent_mem[rd_addr_i];
    rd_size_o   <= size_mem[rd_addr_i];
    rd_rank_o   <= rank_mem[rd_addr_i];
  end

endmodule

[sv/forest_completion_tree_counter.sv]
// ---------------------------------------------------------------------------
// forest_completion_tree_counter
// Counts the spanning trees of a complete graph that contain the given edges,
// using a union-find store and a shared bit-serial modular multiplier.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// request   in         start, busy                 mode_i, first_vertex_i,
//                                                  second_vertex_i
// result    out        result_valid_o (strobe)     tree_count_o, cycle_seen_o
// config    in         cfg_valid_i, cfg_ready_o    cfg_data_i
//
// An edge request reads the store for each of the two root finds (one read
// more than the parent steps), then merges in ST_UNION_P and ST_UNION_S;
// an edge that closes a cycle skips the merge, and rejected edges are ignored.
// A finish request walks the parent store one vertex at a time, and runs a
// multiply for each root, each set exponent bit, each squaring and one last by
// the size product on the shared multiplier.
// After reset and after each finish a clearing pass rewrites every store entry;
// busy stays high through it.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "forest_completion_tree_counter_defines.svh"

module forest_completion_tree_counter import fctc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = FCTC_MAX_VERTICES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             mode_i,
  input  logic [VTX_W-1:0] first_vertex_i,
  input  logic [VTX_W-1:0] second_vertex_i,
  output logic             result_valid_o,
  output logic [MOD_W-1:0] tree_count_o,
  output logic             cycle_seen_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [VTX_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned SW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned RW = $clog2(AW + 1);

  fctc_state_e state_q, state_d;

  logic [VTX_W-1:0] vc_q;
  logic             flag_q, flag_d;
  logic             res_vld_q, res_vld_d;
  logic [MOD_W-1:0] res_cnt_q, res_cnt_d;
  logic             res_cyc_q, res_cyc_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    slot_b_q, slot_b_d;
  logic             find_b_q, find_b_d;
  logic [AW-1:0]    ra_q, ra_d, rb_q, rb_d;
  logic [RW-1:0]    rank_a_q, rank_a_d, rank_b_q, rank_b_d;
  logic [SW-1:0]    size_a_q, size_a_d, size_b_q, size_b_d;
  logic [SW-1:0]    comps_q, comps_d;
  logic [SW-1:0]    exp_q, exp_d;
  logic [MOD_W-1:0] prod_q, prod_d, pw_q, pw_d, base_q, base_d;

  logic [SW-1:0]    n_w;
  logic             edge_ok;
  logic             last_v;
  logic             swap;

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    rd_parent;
  logic [SW-1:0]    rd_size;
  logic [RW-1:0]    rd_rank;
  logic [AW-1:0]    wr_addr;
  fctc_wen_t        wr_en;
  logic [AW-1:0]    wr_parent;
  logic [SW-1:0]    wr_size;
  logic [RW-1:0]    wr_rank;

  logic             mul_start;
  logic [MOD_W-1:0] mul_a, mul_b;
  logic             mul_done;
  logic [MOD_W-1:0] mul_res;

  // Effective vertex count, clamped to the store depth.
  assign n_w = (vc_q == '0) ? SW'(1) :
               (32'(vc_q) > 32'(MAX_VERTICES)) ? SW'(MAX_VERTICES) : SW'(vc_q);

  // An edge is taken only when both endpoints are in range.
  assign edge_ok = (first_vertex_i != '0) && (second_vertex_i != '0) &&
                   (32'(first_vertex_i) <= 32'(n_w)) &&
                   (32'(second_vertex_i) <= 32'(n_w));

  assign last_v = (SW'(idx_q) == n_w - 1'b1);
  assign swap   = rank_a_q > rank_b_q;

  fctc_store #(
    .MAX_VERTICES(MAX_VERTICES),
    .AW(AW),
    .SW(SW),
    .RW(RW)
  ) u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .rd_parent_o(rd_parent),
    .rd_size_o  (rd_size),
    .rd_rank_o  (rd_rank),
    .wr_addr_i  (wr_addr),
    .wr_en_i    (wr_en),
    .wr_parent_i(wr_parent),
    .wr_size_i  (wr_size),
    .wr_rank_i  (wr_rank)
  );

  fctc_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // Sequencer: next state, store and multiplier control.
  always_comb begin
    state_d   = state_q;
    flag_d    = flag_q;
    res_vld_d = 1'b0;
    res_cnt_d = res_cnt_q;
    res_cyc_d = res_cyc_q;
    idx_d     = idx_q;
    slot_b_d  = slot_b_q;
    find_b_d  = find_b_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    rank_a_d  = rank_a_q;
    rank_b_d  = rank_b_q;
    size_a_d  = size_a_q;
    size_b_d  = size_b_q;
    comps_d   = comps_q;
    exp_d     = exp_q;
    prod_d    = prod_q;
    pw_d      = pw_q;
    base_d    = base_q;
    rd_addr   = idx_q;
    wr_addr   = idx_q;
    wr_en     = '0;
    wr_parent = idx_q;
    wr_size   = SW'(1);
    wr_rank   = '0;
    mul_start = 1'b0;
    mul_a     = pw_q;
    mul_b     = base_q;

    unique case (state_q)
      // Rewrite one entry per cycle with its initial value.
      ST_CLEAR: begin
        wr_en  = '{parent: 1'b1, size: 1'b1, rank: 1'b1};
        flag_d = 1'b0;
        idx_d  = idx_q + 1'b1;
        if (32'(idx_q) == MAX_VERTICES - 1) begin
          state_d = ST_IDLE;
        end
      end
      // Take a request.
      ST_IDLE: begin
        if (start) begin
          if (mode_i) begin
            if (flag_q) begin
              res_vld_d = 1'b1;
              res_cnt_d = '0;
              res_cyc_d = 1'b1;
              idx_d     = '0;
              state_d   = ST_CLEAR;
            end else begin
              idx_d   = '0;
              comps_d = '0;
              prod_d  = MOD_W'(1);
              state_d = ST_SCAN_RD;
            end
          end else if (!flag_q && edge_ok) begin
            idx_d    = AW'(first_vertex_i - 1'b1);
            slot_b_d = AW'(second_vertex_i - 1'b1);
            find_b_d = 1'b0;
            state_d  = ST_FIND_RD;
          end
        end
      end
      // Root find: each parent step reads in ST_FIND_RD and checks in ST_FIND_CHK.
      ST_FIND_RD: begin
        state_d = ST_FIND_CHK;
      end
      ST_FIND_CHK: begin
        if (rd_parent == idx_q) begin
          if (!find_b_q) begin
            ra_d     = idx_q;
            rank_a_d = rd_rank;
            size_a_d = rd_size;
            idx_d    = slot_b_q;
            find_b_d = 1'b1;
            state_d  = ST_FIND_RD;
          end else if (idx_q == ra_q) begin
            flag_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            rb_d     = idx_q;
            rank_b_d = rd_rank;
            size_b_d = rd_size;
            state_d  = ST_UNION_P;
          end
        end else begin
          idx_d   = rd_parent;
          state_d = ST_FIND_RD;
        end
      end
      // Hang the lower-ranked root under the other.
      ST_UNION_P: begin
        wr_en.parent = 1'b1;
        wr_addr      = swap ? rb_q : ra_q;
        wr_parent    = swap ? ra_q : rb_q;
        state_d      = ST_UNION_S;
      end
      // Update size and rank of the surviving root.
      ST_UNION_S: begin
        wr_en.size = 1'b1;
        wr_en.rank = 1'b1;
        wr_addr    = swap ? ra_q : rb_q;
        wr_size    = size_a_q + size_b_q;
        wr_rank    = (swap ? rank_a_q : rank_b_q) + RW'(rank_a_q == rank_b_q);
        state_d    = ST_IDLE;
      end
      // Root scan over the active vertices.
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (rd_parent == idx_q) begin
          comps_d   = comps_q + 1'b1;
          mul_start = 1'b1;
          mul_a     = prod_q;
          mul_b     = MOD_W'(rd_size);
          state_d   = ST_SCAN_MUL;
        end else if (last_v) begin
          state_d = ST_SCAN_END;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_MUL: begin
        if (mul_done) begin
          prod_d = mul_res;
          if (last_v) begin
            state_d = ST_SCAN_END;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_SCAN_RD;
          end
        end
      end
      // A single component gives one tree; otherwise raise n to comps-2.
      ST_SCAN_END: begin
        if (comps_q <= SW'(1)) begin
          res_vld_d = 1'b1;
          res_cnt_d = MOD_W'(1);
          res_cyc_d = 1'b0;
          idx_d     = '0;
          state_d   = ST_CLEAR;
        end else begin
          exp_d   = comps_q - SW'(2);
          pw_d    = MOD_W'(1);
          base_d  = MOD_W'(n_w);
          state_d = ST_EXP_CHK;
        end
      end
      // Square and multiply, low exponent bit first.
      ST_EXP_CHK: begin
        mul_start = 1'b1;
        if (exp_q == '0) begin
          mul_b   = prod_q;
          state_d = ST_FINAL;
        end else if (exp_q[0]) begin
          state_d = ST_EXP_MUL;
        end else begin
          mul_a   = base_q;
          state_d = ST_EXP_SQR;
        end
      end
      ST_EXP_MUL: begin
        if (mul_done) begin
          pw_d    = mul_res;
          exp_d   = {exp_q[SW-1:1], 1'b0};
          state_d = ST_EXP_CHK;
        end
      end
      ST_EXP_SQR: begin
        if (mul_done) begin
          base_d  = mul_res;
          exp_d   = exp_q >> 1;
          state_d = ST_EXP_CHK;
        end
      end
      ST_FINAL: begin
        if (mul_done) begin
          res_vld_d = 1'b1;
          res_cnt_d = mul_res;
          res_cyc_d = 1'b0;
          idx_d     = '0;
          state_d   = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        idx_d   = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q      <= VTX_W'(1);
      flag_q    <= 1'b0;
      res_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        vc_q <= cfg_data_i;
      end
      flag_q    <= flag_d;
      res_vld_q <= res_vld_d;
      idx_q     <= idx_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    res_cnt_q <= res_cnt_d;
    res_cyc_q <= res_cyc_d;
    slot_b_q  <= slot_b_d;
    find_b_q  <= find_b_d;
    ra_q      <= ra_d;
    rb_q      <= rb_d;
    rank_a_q  <= rank_a_d;
    rank_b_q  <= rank_b_d;
    size_a_q  <= size_a_d;
    size_b_q  <= size_b_d;
    comps_q   <= comps_d;
    exp_q     <= exp_d;
    prod_q    <= prod_d;
    pw_q      <= pw_d;
    base_q    <= base_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_vld_q;
  assign tree_count_o   = res_cnt_q;
  assign cycle_seen_o   = res_cyc_q;

  // Checks.
  `FCTC_ASSERT_SAME(a_res_in_clear, result_valid_o, busy, "result shown while idle")
  `FCTC_ASSERT_SAME(a_cycle_zero, result_valid_o && cycle_seen_o, tree_count_o == '0,
                    "non-zero count with a cycle")
  `FCTC_ASSERT_NEXT(a_finish_busy, start && !busy && mode_i, busy, "finish did not start")

endmodule
